// ===== hw/rtl/rds_pkg.sv =====
// ---------------------------------------------------------------------------
// rds_pkg: shared types and constants of the request deadline scanner
// Field types, request, connection and result codes, and table geometry.
// ---------------------------------------------------------------------------
`default_nettype none

package rds_pkg;

  localparam int unsigned SlotCountDefault = 32;
  localparam int unsigned TickResetMs      = 100;
  localparam int unsigned NsPerMs          = 1000000;
  // remainder width for the wait division: tick_ms * NsPerMs stays below 2**36
  localparam int unsigned RemW             = 36;
  localparam int unsigned QuoW             = 16;
  // ns to ms: drop the 2**6 factor of NsPerMs, then multiply by 2**44 / 15625
  // rounded up; exact for every remainder below 2**36
  localparam int unsigned DivPreShift      = 6;
  localparam int unsigned RecipW           = 31;
  localparam int unsigned RecipShift       = 44;
  localparam logic [RecipW-1:0] RecipMul   = 31'd1125899907;
  // memory word: deadline, ping mark, parked mark
  localparam int unsigned EntryW           = 66;

  typedef logic [1:0]  req_type_t;
  typedef logic [4:0]  slot_t;
  typedef logic [63:0] ns_t;
  typedef logic [1:0]  conn_t;
  typedef logic [1:0]  kind_t;
  typedef logic [15:0] ms_t;

  localparam req_type_t ReqArm     = 2'd0;
  localparam req_type_t ReqRelease = 2'd1;
  localparam req_type_t ReqScan    = 2'd2;

  localparam conn_t ConnAlive  = 2'd0;
  localparam conn_t ConnRecon  = 2'd1;

  localparam kind_t KindAck     = 2'd0;
  localparam kind_t KindExpired = 2'd1;
  localparam kind_t KindSummary = 2'd2;

endpackage

`default_nettype wire

// ===== hw/rtl/rds_if.sv =====
// ---------------------------------------------------------------------------
// rds_if: request and result channels of the deadline scanner
// Valid/ready channels; a word moves when valid and ready are both high.
// ---------------------------------------------------------------------------
`default_nettype none

interface rds_req_if;
  logic               valid;
  logic               ready;
  rds_pkg::req_type_t req_type;
  rds_pkg::slot_t     slot;
  rds_pkg::ns_t       deadline;
  logic               ping;
  logic               parked;
  rds_pkg::ns_t       now_ns;
  rds_pkg::conn_t     conn_state;

  modport source (output valid, req_type, slot, deadline, ping, parked, now_ns, conn_state,
                  input ready);
  modport sink   (input valid, req_type, slot, deadline, ping, parked, now_ns, conn_state,
                  output ready);
endinterface

interface rds_rsp_if;
  logic           valid;
  logic           ready;
  rds_pkg::kind_t kind;
  rds_pkg::slot_t expired_slot;
  logic           expired_parked;
  logic           expired_ping;
  rds_pkg::ms_t   wait_ms;
  logic           link_dead;
  logic           last;

  modport source (output valid, kind, expired_slot, expired_parked, expired_ping, wait_ms,
                  link_dead, last, input ready);
  modport sink   (input valid, kind, expired_slot, expired_parked, expired_ping, wait_ms,
                  link_dead, last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rds_ram.sv =====
// ---------------------------------------------------------------------------
// rds_ram: generic single-port-write, registered-read memory
// One write and one read per cycle; read data holds while read enable is low.
// ---------------------------------------------------------------------------
`default_nettype none

module rds_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                       wdata_i,
  input  wire logic                                   re_i,
  input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/request_deadline_scanner_top.sv =====
// ---------------------------------------------------------------------------
// request_deadline_scanner_top: request slot table with deadline scan
// Arms and releases request slots and scans them for passed deadlines.
// ---------------------------------------------------------------------------
// Usage
//   req_i carries one word per request: arm, release or scan. rsp_o returns
//   results; the final result of each request has last set. cfg_we_i with
//   cfg_wdata_i writes tick_ms; the user must write it only while the block
//   is idle, which the block itself does not enforce.
//   Arm/release: one acknowledge, loaded into the output register in the
//   accept cycle, so it is visible in the cycle after.
//   Scan: the slot table memory is read one slot per cycle through its single
//   read port while the walk is not stalled; after the walk, S_PREP and S_LIM
//   set up the wait, S_DIV turns the remaining ns into ms by the reciprocal
//   multiply if the wait is below tick_ms and S_SUM loads the summary.
//   A scan whose conn_state is neither alive nor reconnecting skips the walk.
//   One request is in work at a time; req_i.ready is low until its last
//   result is in the output register and the register can take a new word.
//   A stalled receiver holds the output register; the walk pauses on the
//   next expired slot until the register frees up.
//   Reset empties the slot table (valid marks only) and sets tick_ms to 100.
// ---------------------------------------------------------------------------
`default_nettype none

module request_deadline_scanner_top #(
  parameter int unsigned SLOT_COUNT = rds_pkg::SlotCountDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire rds_pkg::ms_t       cfg_wdata_i,
  rds_req_if.sink                 req_i,
  rds_rsp_if.source               rsp_o
);

  import rds_pkg::*;

  localparam int unsigned IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CW = $clog2(SLOT_COUNT + 1);
  localparam int unsigned ProdW = RemW - DivPreShift + RecipW;
  localparam logic [RemW-1:0] DivBase = RemW'(NsPerMs);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PREP,
    S_LIM,
    S_DIV,
    S_SUM
  } state_e;

  state_e            st_q;
  ms_t               tick_q;
  logic [SLOT_COUNT-1:0] valid_q;
  logic [CW-1:0]     rd_cnt_q;
  logic              ev_vld_q;
  logic [IW-1:0]     ev_idx_q;
  logic              want_q;
  ns_t               now_q;
  ns_t               next_q;
  logic              dead_q;
  ns_t               dt_q;
  logic [RemW-1:0]   lim_q;
  logic [RemW-1:0]   rem_q;
  ms_t               wait_q;

  logic              out_vld_q;
  kind_t             out_kind_q;
  slot_t             out_slot_q;
  logic              out_park_q;
  logic              out_ping_q;
  ms_t               out_wait_q;
  logic              out_dead_q;
  logic              out_last_q;

  logic              can_load;
  logic              out_load;
  logic              req_fire;
  logic              arm_in_range;
  logic [IW-1:0]     arm_idx;
  logic              ram_we;
  logic              ram_re;
  logic [EntryW-1:0] ram_rdata;
  ns_t               ev_dl;
  logic              ev_ping;
  logic              ev_park;
  logic              ev_hit;
  logic              ev_exp;
  logic              stall;
  logic [ProdW-1:0]  recip_prod;
  logic [QuoW-1:0]   q_nxt;

  assign can_load     = !out_vld_q || rsp_o.ready;
  assign req_i.ready  = (st_q == S_IDLE) && can_load;
  assign req_fire     = req_i.valid && req_i.ready;
  assign arm_in_range = 32'(req_i.slot) < SLOT_COUNT;
  assign arm_idx      = IW'(req_i.slot);
  assign ram_we       = req_fire && (req_i.req_type == ReqArm) && arm_in_range;

  // entry under evaluation, read the cycle before or held while the walk stalls
  assign ev_dl   = ram_rdata[EntryW-1:2];
  assign ev_ping = ram_rdata[1];
  assign ev_park = ram_rdata[0];
  assign ev_hit  = (st_q == S_SCAN) && ev_vld_q && valid_q[ev_idx_q] &&
                   (ev_park == want_q) && (ev_dl != '0);
  assign ev_exp  = ev_hit && (now_q >= ev_dl);
  assign stall   = ev_exp && !can_load;
  assign ram_re  = (st_q == S_SCAN) && !stall && (rd_cnt_q < CW'(SLOT_COUNT));

  // a word enters the output register this cycle
  assign out_load = (req_fire && (req_i.req_type != ReqScan)) ||
                    (ev_exp && !stall) ||
                    ((st_q == S_SUM) && can_load);

  // remaining ns to whole ms by reciprocal multiply
  assign recip_prod = ProdW'(rem_q[RemW-1:DivPreShift]) * ProdW'(RecipMul);
  assign q_nxt      = recip_prod[RecipShift +: QuoW];

  rds_ram #(
    .Width (EntryW),
    .Depth (SLOT_COUNT)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (arm_idx),
    .wdata_i ({req_i.deadline, req_i.ping, req_i.parked}),
    .re_i    (ram_re),
    .raddr_i (rd_cnt_q[IW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      tick_q    <= ms_t'(TickResetMs);
      valid_q   <= '0;
      rd_cnt_q  <= '0;
      ev_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tick_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
      case (st_q)
        S_IDLE: begin
          if (req_fire) begin
            now_q  <= req_i.now_ns;
            next_q <= '0;
            dead_q <= 1'b0;
            if (req_i.req_type == ReqScan) begin
              want_q   <= (req_i.conn_state == ConnRecon);
              rd_cnt_q <= '0;
              ev_vld_q <= 1'b0;
              if (req_i.conn_state == ConnAlive || req_i.conn_state == ConnRecon) begin
                st_q <= S_SCAN;
              end else begin
                st_q <= S_PREP;
              end
            end else begin
              if (arm_in_range) begin
                if (req_i.req_type == ReqArm) begin
                  valid_q[arm_idx] <= 1'b1;
                end else if (req_i.req_type == ReqRelease) begin
                  valid_q[arm_idx] <= 1'b0;
                end
              end
              out_kind_q <= KindAck;
              out_slot_q <= '0;
              out_park_q <= 1'b0;
              out_ping_q <= 1'b0;
              out_wait_q <= '0;
              out_dead_q <= 1'b0;
              out_last_q <= 1'b1;
            end
          end
        end
        S_SCAN: begin
          if (!stall) begin
            if (ram_re) begin
              ev_vld_q <= 1'b1;
              ev_idx_q <= rd_cnt_q[IW-1:0];
              rd_cnt_q <= rd_cnt_q + CW'(1);
            end else begin
              ev_vld_q <= 1'b0;
              st_q     <= S_PREP;
            end
            if (ev_exp) begin
              valid_q[ev_idx_q] <= 1'b0;
              if (!want_q && ev_ping) begin
                dead_q <= 1'b1;
              end
              out_kind_q <= KindExpired;
              out_slot_q <= slot_t'(ev_idx_q);
              out_park_q <= ev_park;
              out_ping_q <= ev_ping;
              out_wait_q <= '0;
              out_dead_q <= 1'b0;
              out_last_q <= 1'b0;
            end else if (ev_hit && (next_q == '0 || ev_dl < next_q)) begin
              next_q <= ev_dl;
            end
          end
        end
        S_PREP: begin
          dt_q  <= (next_q > now_q) ? next_q - now_q : '0;
          lim_q <= RemW'(tick_q) * DivBase;
          st_q  <= S_LIM;
        end
        S_LIM: begin
          if (next_q == '0) begin
            wait_q <= tick_q;
            st_q   <= S_SUM;
          end else if (dt_q >= ns_t'(lim_q)) begin
            // quotient at or beyond the tick saturates, never below one
            wait_q <= (tick_q == '0) ? ms_t'(1) : tick_q;
            st_q   <= S_SUM;
          end else begin
            rem_q <= dt_q[RemW-1:0];
            st_q  <= S_DIV;
          end
        end
        S_DIV: begin
          wait_q <= q_nxt + ms_t'(1);
          st_q   <= S_SUM;
        end
        S_SUM: begin
          if (can_load) begin
            out_kind_q <= KindSummary;
            out_slot_q <= '0;
            out_park_q <= 1'b0;
            out_ping_q <= 1'b0;
            out_wait_q <= wait_q;
            out_dead_q <= dead_q;
            out_last_q <= 1'b1;
            st_q       <= S_IDLE;
          end
        end
        default: begin
          st_q <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid          = out_vld_q;
  assign rsp_o.kind           = out_kind_q;
  assign rsp_o.expired_slot   = out_slot_q;
  assign rsp_o.expired_parked = out_park_q;
  assign rsp_o.expired_ping   = out_ping_q;
  assign rsp_o.wait_ms        = out_wait_q;
  assign rsp_o.link_dead      = out_dead_q;
  assign rsp_o.last           = out_last_q;

  // an expired slot loses its valid mark once its report is loaded
  a_exp_was_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_exp && !stall |=> !valid_q[$past(ev_idx_q)])
    else $error("expired slot still marked valid");

  // the entry under evaluation never lies past the table
  a_ev_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_vld_q |-> (32'(ev_idx_q) < SLOT_COUNT))
    else $error("evaluated slot out of range");

  // the quotient stays below the tick that bounded the divide
  a_quo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_DIV |-> (q_nxt < tick_q))
    else $error("wait quotient reached the tick");

  // a stall in the walk only happens while the output register is held
  a_stall_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |-> (out_vld_q && !rsp_o.ready))
    else $error("walk stalled with a free output register");

  // the summary closes every scan
  a_sum_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (out_kind_q == KindSummary) |-> out_last_q)
    else $error("summary without last");

endmodule

`default_nettype wire
